// ===== design/assert_macros.svh =====
// Assertion macros shared by the level meter RTL.
// Bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define AFLM_ASSERT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

`define AFLM_ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) else $error(msg);

`else

`define AFLM_ASSERT(lbl, clk_s, rst_s, prop, msg)

`define AFLM_ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg)

`endif

`endif

// ===== design/aflm_pkg.sv =====
// Package for the audio frame level meter: widths, constants, register
// indexes and the command/status types between controller and datapath.
`default_nettype none

package aflm_pkg;

    localparam int MaxFrame = 4096;

    localparam int SAMPLE_W = 16;
    localparam int CNT_W    = 13;
    localparam int ENERGY_W = 43;
    localparam int EXP_W    = 6;
    localparam int FRAC_W   = 16;
    localparam int LOG_W    = EXP_W + FRAC_W;
    localparam int MANT_W   = 31;
    localparam int QUO_W    = 17;
    localparam int LEVEL_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEECH_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEVEL   = 2'd2;

    localparam logic [LEVEL_W-1:0] LEVEL_FLOOR = 16'hA000;  // -24576
    // 2560*log10(2) in Q16, and twice that for magnitude levels
    localparam logic [26:0] DB_K  = 27'd50504453;
    localparam logic [26:0] DB_K2 = 27'd101008906;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCUM,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_LOAD,
        OP_NORM,
        OP_MANT,
        OP_SQUARE,
        OP_STORE,
        OP_CALC,
        OP_MUL_RMS,
        OP_MUL_PEAK,
        OP_FINISH
    } dp_op_t;

    typedef enum logic [1:0] {
        SEL_ENERGY,
        SEL_COUNT,
        SEL_PEAK
    } log_sel_t;

    typedef struct packed {
        dp_op_t   op;
        log_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        logic close;
        logic norm_done;
        logic out_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/aflm_if.sv =====
// Valid/ready channel interfaces for samples in and frame metrics out.
// Depends on aflm_pkg for field widths.
`default_nettype none

interface aflm_in_if;
    import aflm_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       chunk_end;
    modport source (output valid, output sample, output chunk_end, input ready);
    modport sink (input valid, input sample, input chunk_end, output ready);
endinterface

interface aflm_out_if;
    import aflm_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [LEVEL_W-1:0] rms_level;
    logic signed [LEVEL_W-1:0] peak_level;
    logic [QUO_W-1:0]          clip_fraction;
    logic                      speech_flag;
    modport source (output valid, output rms_level, output peak_level,
                    output clip_fraction, output speech_flag, input ready);
    modport sink (input valid, input rms_level, input peak_level,
                  input clip_fraction, input speech_flag, output ready);
endinterface

`default_nettype wire

// ===== design/aflm_dp.sv =====
// Datapath: accumulators, config registers, divider, shared log2 unit
// with one 31x31 multiplier, level conversion and output register. Uses aflm_pkg.
`default_nettype none

`include "assert_macros.svh"

module aflm_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [aflm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [aflm_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic signed [aflm_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                               chunk_end,
    input  wire aflm_pkg::dp_cmd_t                  cmd,
    output aflm_pkg::dp_stat_t                      stat,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [aflm_pkg::LEVEL_W-1:0]     rms_level,
    output logic signed [aflm_pkg::LEVEL_W-1:0]     peak_level,
    output logic [aflm_pkg::QUO_W-1:0]              clip_fraction,
    output logic                                    speech_flag
);
    import aflm_pkg::*;

    // configuration
    logic [CNT_W-1:0]         frame_len_reg;
    logic signed [LEVEL_W-1:0] thr_reg;
    logic [SAMPLE_W-1:0]      clip_lvl_reg;

    // running accumulators
    logic [ENERGY_W-1:0] acc_e_reg;
    logic [SAMPLE_W-1:0] acc_p_reg;
    logic [CNT_W-1:0]    acc_c_reg;
    logic [CNT_W-1:0]    acc_n_reg;

    // closed-frame snapshot
    logic [ENERGY_W-1:0] fe_reg;
    logic [SAMPLE_W-1:0] fp_reg;
    logic [CNT_W-1:0]    fc_reg;
    logic [CNT_W-1:0]    fn_reg;

    // divider
    logic [CNT_W-1:0] rem_reg;
    logic [QUO_W-1:0] q_reg;

    // log2 unit
    logic [ENERGY_W-1:0] norm_reg;
    logic [EXP_W-1:0]    exp_reg;
    logic [MANT_W-1:0]   m_reg;
    logic [FRAC_W-1:0]   frac_reg;
    logic [LOG_W-1:0]    log_e_reg;
    logic [LOG_W-1:0]    log_n_reg;
    logic [LOG_W-1:0]    log_p_reg;

    // level conversion
    logic [LOG_W-1:0]    mag_r_reg;
    logic [LOG_W-1:0]    mag_p_reg;
    logic [48:0]         prod_reg;
    logic [LEVEL_W-1:0]  rms_lev_reg;

    logic                 out_valid_reg;
    logic [LEVEL_W-1:0]   rms_out_reg;
    logic [LEVEL_W-1:0]   peak_out_reg;
    logic [QUO_W-1:0]     frac_out_reg;
    logic                 speech_out_reg;

    // accumulate path
    logic [SAMPLE_W-1:0] s_u;
    logic [SAMPLE_W-1:0] mag;
    logic [31:0]         sq;
    logic [ENERGY_W-1:0] energy_next;
    logic [SAMPLE_W-1:0] peak_next;
    logic [CNT_W-1:0]    clip_next;
    logic [CNT_W-1:0]    cnt_next;
    logic [CNT_W-1:0]    len;
    logic                close;

    assign s_u = sample;
    assign mag = s_u[SAMPLE_W-1] ? (~s_u + 16'd1) : s_u;
    assign sq  = {16'd0, mag} * {16'd0, mag};
    assign energy_next = acc_e_reg + {11'd0, sq};
    assign peak_next   = (mag > acc_p_reg) ? mag : acc_p_reg;
    assign clip_next   = acc_c_reg + {12'd0, (mag >= clip_lvl_reg)};
    assign cnt_next    = acc_n_reg + 13'd1;

    always_comb
    begin
        if (frame_len_reg == '0)
            len = 13'd1;
        else if (frame_len_reg > CNT_W'(MaxFrame))
            len = CNT_W'(MaxFrame);
        else
            len = frame_len_reg;
    end

    assign close = chunk_end || (cnt_next >= len);

    // shared multiplier
    logic [MANT_W-1:0] mul_a;
    logic [MANT_W-1:0] mul_b;
    logic [61:0]       prod;
    logic [31:0]       sq_t;

    always_comb
    begin
        unique case (cmd.op)
            OP_MUL_RMS:
            begin
                mul_a = {9'd0, mag_r_reg};
                mul_b = {4'd0, DB_K};
            end
            OP_MUL_PEAK:
            begin
                mul_a = {9'd0, mag_p_reg};
                mul_b = {4'd0, DB_K2};
            end
            default:
            begin
                mul_a = m_reg;
                mul_b = m_reg;
            end
        endcase
    end

    assign prod = {31'd0, mul_a} * {31'd0, mul_b};
    assign sq_t = prod[61:30];

    logic norm_done;
    assign norm_done = norm_reg[ENERGY_W-1] || (norm_reg == '0);

    // log ratios
    logic signed [23:0] rms_l;
    logic signed [23:0] peak_l;
    assign rms_l  = $signed({2'b00, log_e_reg}) - $signed({2'b00, log_n_reg})
                    - 24'sd1966080;
    assign peak_l = $signed({2'b00, log_p_reg}) - 24'sd983040;

    logic [CNT_W:0] r2;
    assign r2 = {rem_reg, 1'b0};

    function automatic logic [LEVEL_W-1:0] to_level(input logic [48:0] p,
                                                    input logic zero);
        logic [49:0] r;
        logic [17:0] mg;
        r  = {1'b0, p} + 50'h0_0000_8000_0000;
        mg = r[49:32];
        if (zero || (mg > 18'd24576))
            to_level = LEVEL_FLOOR;
        else
            to_level = LEVEL_W'(18'd0 - mg);
    endfunction

    logic [LEVEL_W-1:0] peak_lev;
    logic               speech;
    assign peak_lev = to_level(prod_reg, (fp_reg == '0));
    assign speech = ($signed(rms_lev_reg) >= thr_reg) &&
                    ({1'b0, fc_reg, 1'b0} < {2'b00, fn_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_len_reg <= 13'd160;
            thr_reg       <= -16'sd10240;
            clip_lvl_reg  <= 16'd32000;
            acc_e_reg     <= '0;
            acc_p_reg     <= '0;
            acc_c_reg     <= '0;
            acc_n_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FRAME_LENGTH: frame_len_reg <= cfg_data[CNT_W-1:0];
                    REG_SPEECH_THR:   thr_reg       <= $signed(cfg_data);
                    REG_CLIP_LEVEL:   clip_lvl_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.op == OP_ACCUM)
            begin
                if (close)
                begin
                    acc_e_reg <= '0;
                    acc_p_reg <= '0;
                    acc_c_reg <= '0;
                    acc_n_reg <= '0;
                end
                else
                begin
                    acc_e_reg <= energy_next;
                    acc_p_reg <= peak_next;
                    acc_c_reg <= clip_next;
                    acc_n_reg <= cnt_next;
                end
            end
            if (cmd.op == OP_FINISH)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_ACCUM:
            begin
                if (close)
                begin
                    fe_reg <= energy_next;
                    fp_reg <= peak_next;
                    fc_reg <= clip_next;
                    fn_reg <= cnt_next;
                end
            end
            OP_DIV_INIT:
            begin
                if (fc_reg >= fn_reg)
                begin
                    q_reg   <= 17'd1;
                    rem_reg <= fc_reg - fn_reg;
                end
                else
                begin
                    q_reg   <= '0;
                    rem_reg <= fc_reg;
                end
            end
            OP_DIV_STEP:
            begin
                if (r2 >= {1'b0, fn_reg})
                begin
                    rem_reg <= CNT_W'(r2 - {1'b0, fn_reg});
                    q_reg   <= {q_reg[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= r2[CNT_W-1:0];
                    q_reg   <= {q_reg[QUO_W-2:0], 1'b0};
                end
            end
            OP_LOAD:
            begin
                exp_reg <= 6'd42;
                unique case (cmd.sel)
                    SEL_ENERGY: norm_reg <= fe_reg;
                    SEL_COUNT:  norm_reg <= {30'd0, fn_reg};
                    default:    norm_reg <= {27'd0, fp_reg};
                endcase
            end
            OP_NORM:
            begin
                if (!norm_done)
                begin
                    norm_reg <= {norm_reg[ENERGY_W-2:0], 1'b0};
                    exp_reg  <= exp_reg - 6'd1;
                end
            end
            OP_MANT:
            begin
                m_reg    <= norm_reg[ENERGY_W-1:12];
                frac_reg <= '0;
            end
            OP_SQUARE:
            begin
                // square >= 2.0 gives a one bit and halves the mantissa
                m_reg    <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
                frac_reg <= {frac_reg[FRAC_W-2:0], sq_t[31]};
            end
            OP_STORE:
            begin
                unique case (cmd.sel)
                    SEL_ENERGY: log_e_reg <= {exp_reg, frac_reg};
                    SEL_COUNT:  log_n_reg <= {exp_reg, frac_reg};
                    default:    log_p_reg <= {exp_reg, frac_reg};
                endcase
            end
            OP_CALC:
            begin
                mag_r_reg <= rms_l[23]  ? LOG_W'(-rms_l)  : '0;
                mag_p_reg <= peak_l[23] ? LOG_W'(-peak_l) : '0;
            end
            OP_MUL_RMS:
            begin
                prod_reg <= prod[48:0];
            end
            OP_MUL_PEAK:
            begin
                rms_lev_reg <= to_level(prod_reg, (fe_reg == '0));
                prod_reg    <= prod[48:0];
            end
            OP_FINISH:
            begin
                rms_out_reg    <= rms_lev_reg;
                peak_out_reg   <= peak_lev;
                frac_out_reg   <= q_reg;
                speech_out_reg <= speech;
            end
            default: ;
        endcase
    end

    assign stat.close     = close;
    assign stat.norm_done = norm_done;
    assign stat.out_busy  = out_valid_reg && !out_ready;

    assign out_valid     = out_valid_reg;
    assign rms_level     = $signed(rms_out_reg);
    assign peak_level    = $signed(peak_out_reg);
    assign clip_fraction = frac_out_reg;
    assign speech_flag   = speech_out_reg;

    `AFLM_ASSERT(a_clip_le_cnt, clk, rst_n, acc_c_reg <= acc_n_reg, "clip count above sample count")
    `AFLM_ASSERT_NEVER(a_cnt_max, clk, rst_n, acc_n_reg >= 13'd4096, "frame count overran")
    `AFLM_ASSERT(a_div_rem, clk, rst_n, (cmd.op == OP_DIV_STEP) |-> (rem_reg < fn_reg), "divider remainder out of range")
    `AFLM_ASSERT(a_fin_valid, clk, rst_n, (cmd.op == OP_FINISH) |=> out_valid_reg, "result not presented")

endmodule

`default_nettype wire

// ===== design/aflm_ctrl.sv =====
// Controller: sequences accumulation, divide, the three log2 passes and
// level conversion. Drives datapath commands; uses aflm_pkg types.
`default_nettype none

module aflm_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire aflm_pkg::dp_stat_t  stat,
    output aflm_pkg::dp_cmd_t        cmd
);
    import aflm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_INIT,
        S_DIV,
        S_LOAD,
        S_NORM,
        S_SQUARE,
        S_STORE,
        S_CALC,
        S_MUL_RMS,
        S_MUL_PEAK,
        S_FINISH
    } state_t;

    state_t   state_reg;
    logic [3:0] cnt_reg;
    log_sel_t sel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            sel_reg   <= SEL_ENERGY;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (in_valid && stat.close)
                        state_reg <= S_DIV_INIT;
                S_DIV_INIT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15)
                    begin
                        sel_reg   <= SEL_ENERGY;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                    state_reg <= S_NORM;
                S_NORM:
                    if (stat.norm_done)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_SQUARE;
                    end
                S_SQUARE:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15)
                        state_reg <= S_STORE;
                end
                S_STORE:
                begin
                    if (sel_reg == SEL_PEAK)
                        state_reg <= S_CALC;
                    else
                    begin
                        sel_reg   <= (sel_reg == SEL_ENERGY) ? SEL_COUNT : SEL_PEAK;
                        state_reg <= S_LOAD;
                    end
                end
                S_CALC:     state_reg <= S_MUL_RMS;
                S_MUL_RMS:  state_reg <= S_MUL_PEAK;
                S_MUL_PEAK: state_reg <= S_FINISH;
                S_FINISH:
                    if (!stat.out_busy)
                        state_reg <= S_IDLE;
                default:    state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd.sel = sel_reg;
        unique case (state_reg)
            S_IDLE:     cmd.op = in_valid ? OP_ACCUM : OP_NONE;
            S_DIV_INIT: cmd.op = OP_DIV_INIT;
            S_DIV:      cmd.op = OP_DIV_STEP;
            S_LOAD:     cmd.op = OP_LOAD;
            S_NORM:     cmd.op = stat.norm_done ? OP_MANT : OP_NORM;
            S_SQUARE:   cmd.op = OP_SQUARE;
            S_STORE:    cmd.op = OP_STORE;
            S_CALC:     cmd.op = OP_CALC;
            S_MUL_RMS:  cmd.op = OP_MUL_RMS;
            S_MUL_PEAK: cmd.op = OP_MUL_PEAK;
            S_FINISH:   cmd.op = stat.out_busy ? OP_NONE : OP_FINISH;
            default:    cmd.op = OP_NONE;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

`default_nettype wire

// ===== design/audio_frame_level_meter_core.sv =====
// Top level of the audio frame level meter: controller plus datapath.
// Depends on aflm_pkg, aflm_if, aflm_ctrl and aflm_dp.
`default_nettype none

// Frame RMS/peak/clipping meter for signed 16-bit PCM. Samples that do not
// close a frame are taken one per cycle while the meter is idle. The closing
// sample then starts a frame-end sequence that divides, normalises the
// energy, the sample count and the peak by removing their leading zeros,
// takes their logarithms and converts the levels; no sample is taken during
// it. Its length is set by the shared log2 unit: one-bit-per-cycle
// normalisation followed by sixteen squarings on a single 31x31 multiplier
// for each of the three logarithms. The last cycle also waits while the
// previous result is unread. A finished result sits in an output register,
// so the next frame's samples are taken while it waits to be read.

module audio_frame_level_meter_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [aflm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [aflm_pkg::CFG_W-1:0]      cfg_data,
    aflm_in_if.sink                              in_ch,
    aflm_out_if.source                           out_ch
);
    import aflm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     in_ready;

    aflm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    aflm_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample        (in_ch.sample),
        .chunk_end     (in_ch.chunk_end),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .rms_level     (out_ch.rms_level),
        .peak_level    (out_ch.peak_level),
        .clip_fraction (out_ch.clip_fraction),
        .speech_flag   (out_ch.speech_flag)
    );

    assign in_ch.ready = in_ready;

endmodule

`default_nettype wire
